// ----- rtl/core/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal formatter
// Register indexes, length modes, ASCII codes and converter sizes.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned DCNT_W     = $clog2(BCD_DIGITS + 1);
  localparam int unsigned BCNT_W     = $clog2(VALUE_W);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LEFT_ALIGN  = 3'd0;
  localparam cfg_idx_t REG_ZERO_PAD    = 3'd1;
  localparam cfg_idx_t REG_FORCE_PLUS  = 3'd2;
  localparam cfg_idx_t REG_SPACE_SIGN  = 3'd3;
  localparam cfg_idx_t REG_FIELD_WIDTH = 3'd4;
  localparam cfg_idx_t REG_PRECISION   = 3'd5;
  localparam cfg_idx_t REG_LENGTH_MODE = 3'd6;

  localparam logic [2:0] LEN_INT32    = 3'd0;
  localparam logic [2:0] LEN_CHAR8    = 3'd1;
  localparam logic [2:0] LEN_SHORT16  = 3'd2;
  localparam logic [2:0] LEN_LONG64   = 3'd3;
  localparam logic [2:0] LEN_LLONG64  = 3'd4;

  localparam logic [6:0] PREC_NONE = 7'h7F;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_SHIFT = 3'b010,
    CV_NORM = 3'b100
  } conv_state_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CONV = 8'b0000_0010,
    ST_PRE  = 8'b0000_0100,
    ST_SGN  = 8'b0000_1000,
    ST_MID  = 8'b0001_0000,
    ST_ZRO  = 8'b0010_0000,
    ST_DIG  = 8'b0100_0000,
    ST_PST  = 8'b1000_0000
  } fmt_state_e;

endpackage

// ----- rtl/core/sdf_bin2bcd.sv -----
// ----------------------------------------------------------------------------
// sdf_bin2bcd: bit-serial binary to BCD converter
// Shift-and-add-3, one bit per cycle, then left-justifies the digits one
// digit per cycle and reports the digit count.
// ----------------------------------------------------------------------------
module sdf_bin2bcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sdf_pkg::VALUE_W-1:0]  mag_i,
  output logic                         done_o,
  output logic [sdf_pkg::BCD_W-1:0]    bcd_o,
  output logic [sdf_pkg::DCNT_W-1:0]   ndig_o
);
  import sdf_pkg::*;

  conv_state_e        state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   adj;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [DCNT_W-1:0]  nd_q, nd_d;
  logic               done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    bcnt_d  = bcnt_q;
    nd_d    = nd_q;
    done    = 1'b0;
    case (state_q)
      CV_IDLE: begin
        if (start_i) begin
          bin_d   = mag_i;
          bcd_d   = '0;
          bcnt_d  = BCNT_W'(VALUE_W - 1);
          state_d = CV_SHIFT;
        end
      end
      CV_SHIFT: begin
        bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
        if (bcnt_q == '0) begin
          nd_d    = DCNT_W'(BCD_DIGITS);
          state_d = CV_NORM;
        end else begin
          bcnt_d = bcnt_q - 1'b1;
        end
      end
      CV_NORM: begin
        if (bcd_q[BCD_W-1 -: 4] == 4'd0 && nd_q > DCNT_W'(1)) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          nd_d  = nd_q - 1'b1;
        end else begin
          done    = 1'b1;
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      bcnt_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done;
  assign bcd_o  = bcd_q;
  assign ndig_o = nd_q;

endmodule

// ----- rtl/core/signed_decimal_formatter.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_formatter: printf-style %d text of one signed integer
// Converts a value to decimal and sends its padded, signed text out one
// ASCII character per strobe, with a last marker on the final character.
// ----------------------------------------------------------------------------
// Sequence: the first character follows the bit-serial BCD conversion, digit
//   alignment and a done step, then a silent pass through each empty text
//   segment ahead of it.
// Busy: a new value is taken only once the whole text (at most 61 characters,
//   in six text segments) has been sent; busy stays high until then.
// Reset: async, active low; flags 0, width 0, precision not given, int32.
// ----------------------------------------------------------------------------
module signed_decimal_formatter #(
  parameter int unsigned MAX_FIELD = 60
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  logic signed [sdf_pkg::VALUE_W-1:0] value_i,
  // character stream
  output logic                            char_valid_o,
  output logic [7:0]                      character_o,
  output logic                            last_char_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  sdf_pkg::cfg_idx_t               cfg_index_i,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sdf_pkg::*;

  localparam logic [5:0] MAX_F = 6'(MAX_FIELD);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       left_q, zpad_q, plus_q, space_q;
  logic [5:0] width_q;
  logic [6:0] prec_q;
  logic [2:0] lmode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 1'b0;
      zpad_q  <= 1'b0;
      plus_q  <= 1'b0;
      space_q <= 1'b0;
      width_q <= '0;
      prec_q  <= PREC_NONE;
      lmode_q <= LEN_INT32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEFT_ALIGN:  left_q  <= cfg_data_i[0];
        REG_ZERO_PAD:    zpad_q  <= cfg_data_i[0];
        REG_FORCE_PLUS:  plus_q  <= cfg_data_i[0];
        REG_SPACE_SIGN:  space_q <= cfg_data_i[0];
        REG_FIELD_WIDTH: width_q <= cfg_data_i[5:0];
        REG_PRECISION:   prec_q  <= cfg_data_i;
        REG_LENGTH_MODE: lmode_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: truncate per length mode, split sign and magnitude
  // --------------------------------------------------------------------------
  logic               accept;
  logic [VALUE_W-1:0] v_ext, mag;

  assign accept = start && !busy;

  always_comb begin
    case (lmode_q)
      LEN_CHAR8:   v_ext = {{(VALUE_W-8){value_i[7]}}, value_i[7:0]};
      LEN_SHORT16: v_ext = {{(VALUE_W-16){value_i[15]}}, value_i[15:0]};
      LEN_LONG64,
      LEN_LLONG64: v_ext = value_i;
      default:     v_ext = {{(VALUE_W-32){value_i[31]}}, value_i[31:0]};
    endcase
  end

  assign mag = v_ext[VALUE_W-1] ? (~v_ext + 1'b1) : v_ext;

  // --------------------------------------------------------------------------
  // Decimal conversion
  // --------------------------------------------------------------------------
  logic              cv_done;
  logic [BCD_W-1:0]  cv_bcd;
  logic [DCNT_W-1:0] cv_ndig;

  sdf_bin2bcd u_bin2bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .mag_i  (mag),
    .done_o (cv_done),
    .bcd_o  (cv_bcd),
    .ndig_o (cv_ndig)
  );

  // --------------------------------------------------------------------------
  // Layout: segment lengths once the digit count is known
  // Text = lead pad, sign, mid pad, leading zeros, digits, trailing pad.
  // --------------------------------------------------------------------------
  logic       neg_q, mzero_q;
  logic       prec_given;
  logic [5:0] prec_sat, wid_sat, nd_eff, ndig, pad, zeros;
  logic [6:0] used;
  logic       sign_on;

  assign prec_given = !prec_q[6];
  assign prec_sat   = (prec_q[5:0] > MAX_F) ? MAX_F : prec_q[5:0];
  assign wid_sat    = (width_q > MAX_F) ? MAX_F : width_q;
  // zero with precision 0 prints no digits
  assign nd_eff     = (mzero_q && prec_given && prec_sat == 6'd0) ? 6'd0
                                                                   : 6'(cv_ndig);
  assign ndig       = (prec_given && prec_sat > nd_eff) ? prec_sat : nd_eff;
  assign zeros      = ndig - nd_eff;
  assign sign_on    = neg_q || space_q || plus_q;
  assign used       = {1'b0, ndig} + {6'd0, sign_on};
  assign pad        = ({1'b0, wid_sat} > used) ? 6'({1'b0, wid_sat} - used) : 6'd0;

  // --------------------------------------------------------------------------
  // Emit sequencer: each segment state counts its characters down and moves
  // on without a strobe once its count is zero, also for an empty segment.
  // --------------------------------------------------------------------------
  fmt_state_e       state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [5:0]       rem_q, rem_d;
  logic             sgn_q;
  logic [5:0]       mid_q, zro_q, dig_q, pst_q;
  logic [7:0]       padc_q, signc_q;
  logic [BCD_W-1:0] digs_q, digs_d;
  logic             emit;
  logic [7:0]       ch;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    digs_d  = digs_q;
    emit    = 1'b0;
    ch      = CH_SPACE;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cv_done) begin
          digs_d  = cv_bcd;
          cnt_d   = (!left_q && !zpad_q) ? pad : 6'd0;
          rem_d   = pad + ndig + {5'd0, sign_on};
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        ch = padc_q;
        if (cnt_q != '0) emit = 1'b1;
        else begin
          cnt_d   = {5'd0, sgn_q};
          state_d = ST_SGN;
        end
      end
      ST_SGN: begin
        ch = signc_q;
        if (cnt_q != '0) emit = 1'b1;
        else begin
          cnt_d   = mid_q;
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        ch = padc_q;
        if (cnt_q != '0) emit = 1'b1;
        else begin
          cnt_d   = zro_q;
          state_d = ST_ZRO;
        end
      end
      ST_ZRO: begin
        ch = CH_ZERO;
        if (cnt_q != '0) emit = 1'b1;
        else begin
          cnt_d   = dig_q;
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        ch = CH_ZERO | {4'd0, digs_q[BCD_W-1 -: 4]};
        if (cnt_q != '0) begin
          emit   = 1'b1;
          digs_d = {digs_q[BCD_W-5:0], 4'd0};
        end else begin
          cnt_d   = pst_q;
          state_d = ST_PST;
        end
      end
      ST_PST: begin
        ch = padc_q;
        if (cnt_q != '0) emit = 1'b1;
        else state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

  // payload: captured at accept and at conversion done
  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
    if (accept) begin
      neg_q   <= v_ext[VALUE_W-1];
      mzero_q <= (v_ext == '0);
    end
    if (state_q == ST_CONV && cv_done) begin
      sgn_q   <= sign_on;
      mid_q   <= (!left_q && zpad_q) ? pad : 6'd0;
      zro_q   <= zeros;
      dig_q   <= nd_eff;
      pst_q   <= left_q ? pad : 6'd0;
      padc_q  <= (zpad_q && !prec_given && !left_q) ? CH_ZERO : CH_SPACE;
      signc_q <= neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign char_valid_o = emit;
  assign character_o  = ch;
  assign last_char_o  = emit && (rem_q == 6'd1);

endmodule

// ----- rtl/core/sdf_checker.sv -----
// ----------------------------------------------------------------------------
// sdf_checker: port-level assertions for the signed decimal formatter
// Watches command, strobe and last marker over time.
// ----------------------------------------------------------------------------
module sdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       char_valid_o,
  input logic       last_char_o
);

  // no character leaves while the block is idle
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> busy)
    else $error("character strobe while idle");

  // an accepted item makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // the last character closes the text: no strobe right after it
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_char_o) |=> !char_valid_o)
    else $error("character after last marker");

  // last marker only rides on a strobe
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> char_valid_o)
    else $error("last marker without strobe");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .char_valid_o(char_valid_o),
  .last_char_o (last_char_o)
);
